// ===== src/dcl_pkg.sv =====
package dcl_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int PROG_W      = 5;
  localparam int CFG_DATA_W  = 9;
  localparam logic [8:0] POSITIONS_MAX   = 9'd256;
  localparam logic [8:0] POSITIONS_RESET = 9'd10;
  localparam logic [4:0] ENTRIES_RESET   = 5'd4;

  typedef enum logic {
    ACT_CODE_WRITE = 1'b0,
    ACT_SAMPLE     = 1'b1
  } action_t;

  typedef enum logic {
    CFG_DIAL_POSITIONS = 1'b0,
    CFG_CODE_ENTRIES   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_ADVANCE = 2'd1,
    OUT_FAIL    = 2'd2,
    OUT_OPEN    = 2'd3
  } outcome_t;

  typedef struct packed {
    action_t                action;
    logic [4:0]             entry_index;
    logic [7:0]             entry_value;
    logic [SAMPLE_BITS-1:0] raw_sample;
  } item_t;

  typedef struct packed {
    logic [7:0]        position;
    outcome_t          outcome;
    logic [PROG_W-1:0] progress;
  } result_t;

  // One operation arriving at the sequence check: a delayed code write or a
  // finished dial position.
  typedef struct packed {
    logic       valid;
    logic       is_write;
    logic [4:0] entry_index;
    logic [7:0] entry_value;
    logic [7:0] position;
  } seq_op_t;

endpackage

// ===== src/dcl_seq_check.sv =====
module dcl_seq_check
  import dcl_pkg::*;
#(
  parameter int CODE_DEPTH = 23
) (
  input  logic       clk,
  input  logic       rst,
  input  seq_op_t    op,
  output logic       op_ready,
  input  logic       entries_we,
  input  logic [4:0] entries_data,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result
);

  localparam int AW = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;

  logic [7:0]        code_mem [CODE_DEPTH];
  logic [7:0]        rd_prev;
  logic [7:0]        rd_cur;
  logic              prev_zero;
  logic [PROG_W-1:0] progress;
  logic [PROG_W-1:0] progress_next;
  logic [4:0]        code_entries;

  logic              fire;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     addr_prev;
  logic [AW-1:0]     addr_cur;
  logic [5:0]        n_eff;
  logic [7:0]        c_prev;
  logic [5:0]        p_step;
  logic [PROG_W-1:0] p_new;
  outcome_t          outcome;

  assign op_ready = op.is_write || !result_valid || result_ready;
  assign fire     = op.valid && op_ready;
  assign wr_en    = fire && op.is_write && ({1'b0, op.entry_index} < 6'(CODE_DEPTH));
  assign wr_addr  = AW'(op.entry_index);

  always_comb begin
    if (code_entries == 5'd0) begin
      n_eff = 6'd1;
    end else if ({1'b0, code_entries} > 6'(CODE_DEPTH)) begin
      n_eff = 6'(CODE_DEPTH);
    end else begin
      n_eff = {1'b0, code_entries};
    end
  end

  // The first entry of the sequence is an implicit zero.
  assign c_prev = prev_zero ? 8'd0 : rd_prev;

  always_comb begin
    p_step  = {1'b0, progress};
    outcome = OUT_NONE;
    if ((progress[0] && op.position < c_prev) || (!progress[0] && op.position > c_prev)) begin
      p_step  = 6'd1;
      outcome = OUT_FAIL;
    end else if (op.position == rd_cur) begin
      p_step  = p_step + 6'd1;
      outcome = OUT_ADVANCE;
    end
    if (p_step == n_eff + 6'd1) begin
      p_step  = 6'd1;
      outcome = OUT_OPEN;
    end
    p_new = PROG_W'(p_step);
  end

  always_comb begin
    progress_next = progress;
    if (rst || entries_we) begin
      progress_next = PROG_W'(1);
    end else if (fire && !op.is_write) begin
      progress_next = p_new;
    end
  end

  // Read addresses follow the progress of the next cycle, so the read data
  // always holds the previous and the expected entry for the current progress.
  assign addr_cur  = AW'(progress_next - PROG_W'(1));
  assign addr_prev = (progress_next >= PROG_W'(2)) ? AW'(progress_next - PROG_W'(2)) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_addr] <= op.entry_value;
    end
    if (wr_en && wr_addr == addr_prev) begin
      rd_prev <= op.entry_value;
    end else begin
      rd_prev <= code_mem[addr_prev];
    end
    if (wr_en && wr_addr == addr_cur) begin
      rd_cur <= op.entry_value;
    end else begin
      rd_cur <= code_mem[addr_cur];
    end
    prev_zero <= (progress_next == PROG_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      progress     <= PROG_W'(1);
      code_entries <= ENTRIES_RESET;
      result_valid <= 1'b0;
    end else begin
      progress <= progress_next;
      if (entries_we) begin
        code_entries <= entries_data;
      end
      if (fire && !op.is_write) begin
        result_valid    <= 1'b1;
        result.position <= op.position;
        result.outcome  <= outcome;
        result.progress <= p_new;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/dial_combination_lock.sv =====
// Dial combination lock. Each request either writes one code table entry or
// delivers one raw converter sample. Every AVG_SAMPLES samples the sum is
// averaged, scaled to a dial position (average * min(dial_positions, 256) / 4096) and
// checked against the stored code sequence, whose first entry is an implicit
// zero; that sample yields exactly one result, all other requests yield none.
// The block takes one request per cycle while item_ready is high. A result
// is valid after the request completing the average is accepted, through four
// register stages: accumulate, divide by reciprocal multiply, scale, and one
// compare step against two registered reads of the code table memory, which is
// indexed by the current progress. Code writes pass through the same stages,
// so they take effect in request order. The code table is not cleared by
// reset; every entry the sequence uses must be written first. While a result
// waits, samples that do not complete an average are still taken; once a
// completed average is held in the last stage, code writes and further
// averages queue behind it and the input stalls when all three stages are full.
module dial_combination_lock
  import dcl_pkg::*;
#(
  parameter int CODE_DEPTH  = 23,
  parameter int AVG_SAMPLES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(AVG_SAMPLES);
  localparam int DIV_SH = SUM_W + $clog2(AVG_SAMPLES);
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SH) + AVG_SAMPLES - 1) / AVG_SAMPLES;
  localparam logic [SUM_W:0] RECIP = RECIP_L[SUM_W:0];

  typedef struct packed {
    logic       is_write;
    logic [4:0] entry_index;
    logic [7:0] entry_value;
  } wr_info_t;

  logic [SUM_W-1:0]        sample_sum;
  logic [CNT_W-1:0]        sample_count;
  logic [8:0]              dial_positions;

  logic                    s1_valid;
  wr_info_t                s1_info;
  logic [SUM_W-1:0]        s1_total;
  logic                    s2_valid;
  wr_info_t                s2_info;
  logic [SAMPLE_BITS-1:0]  s2_avg;
  seq_op_t                 s3_op;

  logic                    op_ready;
  logic                    r1;
  logic                    r2;
  logic                    r3;
  logic                    accept;
  logic                    is_sample;
  logic                    count_last;
  logic [SUM_W-1:0]        total;
  logic [2*SUM_W:0]        quot_prod;
  logic [8:0]              positions_eff;
  logic [SAMPLE_BITS+8:0]  scale_prod;

  assign r3         = !s3_op.valid || op_ready;
  assign r2         = !s2_valid || r3;
  assign r1         = !s1_valid || r2;
  assign item_ready = r1;
  assign accept     = item_valid && item_ready;
  assign is_sample  = (item.action == ACT_SAMPLE);
  assign count_last = (sample_count == CNT_W'(AVG_SAMPLES - 1));
  assign total      = sample_sum + SUM_W'(item.raw_sample);

  // Exact floor division by AVG_SAMPLES: the reciprocal is rounded up and the
  // shift leaves enough guard bits for every sum that can occur.
  assign quot_prod     = (2*SUM_W+1)'(s1_total) * (2*SUM_W+1)'(RECIP);
  assign positions_eff = (dial_positions > POSITIONS_MAX) ? POSITIONS_MAX : dial_positions;
  assign scale_prod    = (SAMPLE_BITS+9)'(s2_avg) * (SAMPLE_BITS+9)'(positions_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum     <= '0;
      sample_count   <= '0;
      dial_positions <= POSITIONS_RESET;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_DIAL_POSITIONS) begin
        dial_positions <= cfg_data;
      end
      if (accept && is_sample) begin
        if (count_last) begin
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= total;
          sample_count <= sample_count + CNT_W'(1);
        end
      end
      if (r1) begin
        s1_valid <= accept && (!is_sample || count_last);
      end
      if (r2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_info.is_write    <= !is_sample;
      s1_info.entry_index <= item.entry_index;
      s1_info.entry_value <= item.entry_value;
      s1_total            <= total;
    end
    if (r2) begin
      s2_info <= s1_info;
      s2_avg  <= quot_prod[DIV_SH +: SAMPLE_BITS];
    end
    if (rst) begin
      s3_op.valid <= 1'b0;
    end else if (r3) begin
      s3_op.valid <= s2_valid;
    end
    if (r3) begin
      s3_op.is_write    <= s2_info.is_write;
      s3_op.entry_index <= s2_info.entry_index;
      s3_op.entry_value <= s2_info.entry_value;
      s3_op.position    <= scale_prod[SAMPLE_BITS +: 8];
    end
  end

  dcl_seq_check #(
    .CODE_DEPTH(CODE_DEPTH)
  ) u_seq_check (
    .clk          (clk),
    .rst          (rst),
    .op           (s3_op),
    .op_ready     (op_ready),
    .entries_we   (cfg_we && cfg_index == CFG_CODE_ENTRIES),
    .entries_data (cfg_data[4:0]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== src/dcl_checker.sv =====
module dcl_checker
  import dcl_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_restart_progress: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.outcome == OUT_FAIL || result.outcome == OUT_OPEN)
      |-> result.progress == 5'd1)
    else $error("failure or open did not restart the sequence");

  a_advance_progress: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.outcome == OUT_ADVANCE |-> result.progress > 5'd1)
    else $error("advance left progress at the start");

  a_progress_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.progress != 5'd0)
    else $error("progress is zero");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind dial_combination_lock dcl_checker u_dcl_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== dv/dial_combination_lock_test.sv =====
import dcl_pkg::*;

localparam int CODE_DEPTH  = 23;
localparam int AVG_SAMPLES = 64;

// Tracks the lock state request by request and keeps the results still owed.
class lock_scoreboard;
  logic [7:0]  code_table [CODE_DEPTH];
  logic [8:0]  dial_positions;
  logic [4:0]  code_entries;
  logic [4:0]  progress;
  logic [17:0] sample_sum;
  int unsigned sample_count;
  result_t     pending_results [$];
  int unsigned predicted;
  int unsigned errors;

  function new();
    foreach (code_table[k]) code_table[k] = '0;
    dial_positions = POSITIONS_RESET;
    code_entries   = ENTRIES_RESET;
    progress       = 5'd1;
    sample_sum     = '0;
    sample_count   = 0;
    predicted      = 0;
    errors         = 0;
  endfunction

  function int unsigned eff_positions();
    return (dial_positions > POSITIONS_MAX) ? POSITIONS_MAX : dial_positions;
  endfunction

  function int unsigned eff_entries();
    if (code_entries == 0) return 1;
    if (code_entries > CODE_DEPTH) return CODE_DEPTH;
    return code_entries;
  endfunction

  // Entry zero of the sequence is the implied leading zero.
  function int unsigned code_at(int unsigned k);
    if (k == 0 || k > CODE_DEPTH) return 0;
    return code_table[k-1];
  endfunction

  function int unsigned live_progress();
    if (progress < 1 || progress > eff_entries()) return 1;
    return progress;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [8:0] data);
    if (idx == CFG_DIAL_POSITIONS) begin
      dial_positions = data;
    end else begin
      code_entries = data[4:0];
      progress     = 5'd1;
    end
  endfunction

  function void note_request(item_t req);
    int unsigned avg, pos, last, p;
    outcome_t    verdict;
    result_t     next_result;
    if (req.action == ACT_CODE_WRITE) begin
      if (req.entry_index < CODE_DEPTH) code_table[req.entry_index] = req.entry_value;
      return;
    end
    sample_sum += req.raw_sample;
    sample_count++;
    if (sample_count < AVG_SAMPLES) return;
    avg          = sample_sum / AVG_SAMPLES;
    sample_sum   = '0;
    sample_count = 0;
    pos = (avg * eff_positions()) >> SAMPLE_BITS;
    if (pos > 255) pos = 255;
    last    = eff_entries();
    p       = live_progress();
    verdict = OUT_NONE;
    // Odd steps must not fall below the previous entry, even steps must not rise above it.
    if ((p[0] && pos < code_at(p - 1)) || (!p[0] && pos > code_at(p - 1))) begin
      p       = 1;
      verdict = OUT_FAIL;
    end else if (pos == code_at(p)) begin
      p++;
      verdict = OUT_ADVANCE;
    end
    if (p == last + 1) begin
      p       = 1;
      verdict = OUT_OPEN;
    end
    progress = p[4:0];
    next_result.position = pos[7:0];
    next_result.outcome  = verdict;
    next_result.progress = p[4:0];
    pending_results.push_back(next_result);
    predicted++;
  endfunction

  task report_mismatch(string msg);
    $display("%0t ns lock check: %s", $time, msg);
    errors++;
  endtask

  task check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with none pending: position %0d outcome %0d progress %0d",
                                got.position, got.outcome, got.progress));
      return;
    end
    want = pending_results.pop_front();
    if (got.position !== want.position)
      report_mismatch($sformatf("position %0d, predicted %0d", got.position, want.position));
    if (got.outcome !== want.outcome)
      report_mismatch($sformatf("outcome %0d, predicted %0d", got.outcome, want.outcome));
    if (got.progress !== want.progress)
      report_mismatch($sformatf("progress %0d, predicted %0d", got.progress, want.progress));
  endtask
endclass

module dial_combination_lock_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 4000;
  localparam int RANDOM_ITEMS    = 300;
  localparam int RANDOM_RESULTS  = 4;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_ready;
  item_t                 item         = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  cfg_we       = 1'b0;
  cfg_reg_t              cfg_index    = CFG_DIAL_POSITIONS;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  lock_scoreboard sb;
  int unsigned    items_sent    = 0;
  bit             sender_calm   = 1'b0;
  int             hold_off_asks = 0;
  int             hold_off_seen = 0;
  int             stall_left    = 0;
  int             calm_left     = 0;
  int             idle_cycles   = 0;

  dial_combination_lock uut (.*);

  always #1 clk = ~clk;

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
    if (hold_off_seen != hold_off_asks) begin
      hold_off_seen = hold_off_asks;
      stall_left    = HOLD_OFF_CYCLES;
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      result_ready <= 1'b1;
    end else begin
      case ($urandom_range(99)) inside
        [0:2]:   begin calm_left  = $urandom_range(200, 50); result_ready <= 1'b1; end
        [3:69]:  result_ready <= 1'b1;
        [70:94]: begin stall_left = $urandom_range(2);       result_ready <= 1'b0; end
        default: begin stall_left = $urandom_range(60, 10);  result_ready <= 1'b0; end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (item_valid && item_ready) || (result_valid && result_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  task automatic send_item(item_t req);
    int unsigned gap;
    item_valid <= 1'b1;
    item       <= req;
    do @(posedge clk); while (!item_ready);
    sb.note_request(req);
    if (req.action == ACT_SAMPLE || req.entry_index < CODE_DEPTH) items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_code(logic [4:0] idx, logic [7:0] val);
    item_t req;
    req.action      = ACT_CODE_WRITE;
    req.entry_index = idx;
    req.entry_value = val;
    req.raw_sample  = 12'($urandom_range(4095));
    send_item(req);
  endtask

  task automatic send_sample(logic [11:0] val);
    item_t req;
    req.action      = ACT_SAMPLE;
    req.entry_index = 5'($urandom_range(31));
    req.entry_value = 8'($urandom_range(255));
    req.raw_sample  = val;
    send_item(req);
  endtask

  // Mostly harmless writes: out of range or past the live sequence; a few hit any entry.
  task automatic send_code_noise();
    int unsigned r, n;
    r = $urandom_range(7);
    n = sb.eff_entries();
    if (r < 5)
      send_code(5'($urandom_range(31, CODE_DEPTH)), 8'($urandom_range(255)));
    else if (r < 7 && n < CODE_DEPTH)
      send_code(5'($urandom_range(CODE_DEPTH - 1, n)), 8'($urandom_range(255)));
    else
      send_code(5'($urandom_range(CODE_DEPTH - 1)), 8'($urandom_range(255)));
  endtask

  task automatic send_flat(logic [11:0] val);
    for (int left = AVG_SAMPLES - int'(sb.sample_count); left > 0; left--) send_sample(val);
  endtask

  // Finishes the current average so that it lands on the target position. Each
  // sample is drawn around the share still needed, so the sum tracks the goal.
  task automatic send_window(int target, int spread, int noise_pct);
    int top, avg, total, need, share, lo, hi;
    top = int'(sb.eff_positions());
    if (target < 0 || top == 0) begin
      avg = $urandom_range(4095);
    end else begin
      if (target >= top) target = top - 1;
      avg = (target * 4096 + top - 1) / top;
    end
    total = avg * AVG_SAMPLES + int'($urandom_range(AVG_SAMPLES - 1));
    for (int left = AVG_SAMPLES - int'(sb.sample_count); left > 0; left--) begin
      if ($urandom_range(99) < noise_pct) send_code_noise();
      need  = total - int'(sb.sample_sum);
      share = need / left;
      lo    = (left == 1) ? share : share - spread;
      hi    = (left == 1) ? share : share + spread;
      lo    = (lo < 0) ? 0 : (lo > 4095) ? 4095 : lo;
      hi    = (hi < 0) ? 0 : (hi > 4095) ? 4095 : hi;
      if (lo > hi) lo = hi;
      send_sample(12'($urandom_range(hi, lo)));
    end
  endtask

  task automatic send_next_step();
    send_window(int'(sb.code_at(sb.live_progress())), $urandom_range(600), 0);
  endtask

  // A well-formed code rises or holds on odd steps and falls or holds on even ones.
  task automatic write_code(bit well_formed, int unsigned count);
    int unsigned top, prev, v;
    top  = (sb.eff_positions() == 0) ? 0 : sb.eff_positions() - 1;
    prev = 0;
    for (int unsigned k = 1; k <= count; k++) begin
      if (!well_formed) v = $urandom_range(255);
      else if (k[0])    v = $urandom_range(top, prev);
      else              v = $urandom_range(prev, 0);
      send_code(5'(k - 1), 8'(v));
      prev = v;
    end
  endtask

  // Code writes give no result, so allow the pipeline to empty after the last one.
  task automatic pause_until_idle();
    item_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(bit do_pos, logic [8:0] pos_data, bit do_ent, logic [8:0] ent_data);
    if (do_pos) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_DIAL_POSITIONS;
      cfg_data  <= pos_data;
      @(posedge clk);
      sb.write_reg(CFG_DIAL_POSITIONS, pos_data);
    end
    if (do_ent) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_CODE_ENTRIES;
      cfg_data  <= ent_data;
      @(posedge clk);
      sb.write_reg(CFG_CODE_ENTRIES, ent_data);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned items0, results0, pick;
    int          spread;
    logic [8:0]  new_pos, new_ent;
    bit          do_pos, do_ent;

    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: ten positions, four entries. The whole table is written first.
    send_code(5'd23, 8'hFF);
    send_code(5'd31, 8'h00);
    write_code(1'b1, CODE_DEPTH);
    send_code(5'd0, 8'd5);
    send_code(5'd1, 8'd2);
    send_code(5'd2, 8'd8);
    send_code(5'd3, 8'd3);
    send_flat(12'd0);
    send_flat(12'hFFF);
    repeat (4) send_next_step();
    send_next_step();
    send_window(6, 0, 0);
    repeat (2) send_next_step();
    send_window(1, 0, 0);
    // A code write in the middle of an average must not disturb the sum.
    repeat (32) send_sample(12'd0);
    send_code(5'd20, 8'd77);
    send_flat(12'd0);

    // Zero positions and zero entries.
    pause_until_idle();
    set_regs(1'b1, 9'd0, 1'b1, 9'd0);
    send_flat(12'hFFF);
    send_code(5'd0, 8'd0);
    send_flat(12'hABC);

    // Both registers above their range, with the result side held off while the
    // sender keeps going, so that the block fills up and stalls its input.
    pause_until_idle();
    set_regs(1'b1, 9'd511, 1'b1, 9'd31);
    write_code(1'b1, CODE_DEPTH);
    sender_calm = 1'b1;
    hold_off_asks++;
    repeat (6) send_next_step();
    sender_calm = 1'b0;
    send_flat(12'hFFF);

    pause_until_idle();
    set_regs(1'b1, 9'd1, 1'b1, 9'd1);
    write_code(1'b1, 1);
    send_next_step();
    send_flat(12'd0);

    pause_until_idle();
    set_regs(1'b1, POSITIONS_MAX, 1'b1, {4'hF, 5'd23});
    write_code(1'b1, CODE_DEPTH);
    repeat (3) send_next_step();

    items0   = items_sent;
    results0 = sb.predicted;
    while (items_sent - items0 < RANDOM_ITEMS || sb.predicted - results0 < RANDOM_RESULTS) begin
      pause_until_idle();
      sender_calm = ($urandom_range(3) == 0);
      do_pos = ($urandom_range(9) < 6);
      do_ent = ($urandom_range(9) < 6);
      case ($urandom_range(7))
        0:       new_pos = 9'd0;
        1:       new_pos = 9'd1;
        2:       new_pos = POSITIONS_MAX;
        3:       new_pos = 9'd511;
        4:       new_pos = 9'($urandom_range(511, 257));
        default: new_pos = 9'($urandom_range(255, 2));
      endcase
      case ($urandom_range(5))
        0:       new_ent = 9'd0;
        1:       new_ent = 9'd1;
        2:       new_ent = 9'(CODE_DEPTH);
        3:       new_ent = 9'($urandom_range(31, 24));
        4:       new_ent = 9'($urandom_range(22, 7));
        default: new_ent = 9'($urandom_range(6, 2));
      endcase
      new_ent[8:5] = 4'($urandom_range(15));
      set_regs(do_pos, new_pos, do_ent, new_ent);
      write_code($urandom_range(4) != 0, sb.eff_entries());
      repeat ($urandom_range(6, 2)) begin
        pick   = $urandom_range(99);
        spread = $urandom_range(600);
        if (pick < 65)
          send_window(int'(sb.code_at(sb.live_progress())), spread, 2);
        else if (pick < 80)
          send_window($urandom_range(255), spread, 2);
        else if (pick < 90)
          send_window(-1, 4095, 2);
        else
          repeat ($urandom_range(AVG_SAMPLES - 1, 1)) send_sample(12'($urandom_range(4095)));
      end
    end

    pause_until_idle();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dcl_pkg.sv
src/dcl_seq_check.sv
src/dial_combination_lock.sv
src/dcl_checker.sv
dv/dial_combination_lock_test.sv
